[rtl/core/gas_sensor_heater_cycle_ppm_top_defines.svh]
// assertion macros for the gas sensor heater cycle block
// used by the top level only, no other dependencies
`ifndef GAS_SENSOR_HEATER_CYCLE_PPM_TOP_DEFINES_SVH
`define GAS_SENSOR_HEATER_CYCLE_PPM_TOP_DEFINES_SVH

// same-cycle implication
`define GSHC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gshc assertion failed");

// next-cycle implication
`define GSHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gshc assertion failed");

`endif

[rtl/core/gshc_pkg.sv]
// shared types, constants and the square root table for the heater cycle block
// no dependencies
`default_nettype none

package gshc_pkg;

   localparam int ADC_BITS = 12;
   localparam int VOLT_W   = ADC_BITS + 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CMD_DEPTH  = 2;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

   localparam logic [31:0] HIGH_DEFAULT_MS = 32'd60000;
   localparam logic [31:0] LOW_DEFAULT_MS  = 32'd90000;

   localparam logic [31:0] RST_HIGH_PHASE   = 32'd60000;
   localparam logic [31:0] RST_LOW_PHASE    = 32'd90000;
   localparam logic [23:0] RST_VOLTS_CODE   = 24'd13521;
   localparam logic [19:0] RST_SUPPLY       = 20'd327680;
   localparam logic [31:0] RST_LOAD_OHMS    = 32'd2560000;
   localparam logic [31:0] RST_CLEAN_OHMS   = 32'd2560000;
   localparam logic [31:0] RST_CURVE_SCALE  = 32'd6490816;
   localparam logic [19:0] RST_CURVE_EXP    = 20'hE7B64;

   typedef enum logic [2:0] {
      REG_HIGH_PHASE   = 3'd0,
      REG_LOW_PHASE    = 3'd1,
      REG_VOLTS_CODE   = 3'd2,
      REG_SUPPLY       = 3'd3,
      REG_LOAD_OHMS    = 3'd4,
      REG_CLEAN_OHMS   = 3'd5,
      REG_CURVE_SCALE  = 3'd6,
      REG_CURVE_EXP    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0] high_phase_ms;
      logic [31:0] low_phase_ms;
      logic [23:0] volts_per_code;
      logic [19:0] supply_volts;
      logic [31:0] load_ohms;
      logic [31:0] clean_air_ohms;
      logic [31:0] curve_scale;
      logic [19:0] curve_exponent;
   } cfg_type;

   typedef struct packed {
      logic                restart;
      logic                measure;
      logic                heater;
      logic [ADC_BITS-1:0] sample;
   } cmd_type;

   function automatic logic [63:0] isqrt64(logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] b;
      x   = x_in;
      res = 64'd0;
      b   = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + b) begin
            x   = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // successive square roots of 2.0 in q2.30, entry j for the j-th fraction bit from the top
   function automatic logic [15:0][31:0] build_root_table();
      logic [15:0][31:0] tab;
      logic [63:0]       r;
      r = 64'h8000_0000;
      for (int j = 0; j < 16; j++) begin
         r      = isqrt64(r << 30);
         tab[j] = r[31:0];
      end
      return tab;
   endfunction

   localparam logic [15:0][31:0] ROOT_TABLE = build_root_table();

endpackage

`default_nettype wire

[rtl/core/gshc_csr.sv]
// configuration registers behind the apb-style port
// depends on gshc_pkg
`default_nettype none

module gshc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [gshc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   output gshc_pkg::cfg_type                    cfg
);

   gshc_pkg::cfg_type      cfg_ff;
   gshc_pkg::csr_index_type idx;
   logic                    wr_en;

   assign idx        = gshc_pkg::csr_index_type'(csr_paddr[gshc_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_phase_ms  <= gshc_pkg::RST_HIGH_PHASE;
         cfg_ff.low_phase_ms   <= gshc_pkg::RST_LOW_PHASE;
         cfg_ff.volts_per_code <= gshc_pkg::RST_VOLTS_CODE;
         cfg_ff.supply_volts   <= gshc_pkg::RST_SUPPLY;
         cfg_ff.load_ohms      <= gshc_pkg::RST_LOAD_OHMS;
         cfg_ff.clean_air_ohms <= gshc_pkg::RST_CLEAN_OHMS;
         cfg_ff.curve_scale    <= gshc_pkg::RST_CURVE_SCALE;
         cfg_ff.curve_exponent <= gshc_pkg::RST_CURVE_EXP;
      end else if (wr_en) begin
         unique case (idx)
            gshc_pkg::REG_HIGH_PHASE:  cfg_ff.high_phase_ms  <= csr_pwdata;
            gshc_pkg::REG_LOW_PHASE:   cfg_ff.low_phase_ms   <= csr_pwdata;
            gshc_pkg::REG_VOLTS_CODE:  cfg_ff.volts_per_code <= csr_pwdata[23:0];
            gshc_pkg::REG_SUPPLY:      cfg_ff.supply_volts   <= csr_pwdata[19:0];
            gshc_pkg::REG_LOAD_OHMS:   cfg_ff.load_ohms      <= csr_pwdata;
            gshc_pkg::REG_CLEAN_OHMS:  cfg_ff.clean_air_ohms <= csr_pwdata;
            gshc_pkg::REG_CURVE_SCALE: cfg_ff.curve_scale    <= csr_pwdata;
            gshc_pkg::REG_CURVE_EXP:   cfg_ff.curve_exponent <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         gshc_pkg::REG_HIGH_PHASE:  csr_prdata = cfg_ff.high_phase_ms;
         gshc_pkg::REG_LOW_PHASE:   csr_prdata = cfg_ff.low_phase_ms;
         gshc_pkg::REG_VOLTS_CODE:  csr_prdata = {8'd0, cfg_ff.volts_per_code};
         gshc_pkg::REG_SUPPLY:      csr_prdata = {12'd0, cfg_ff.supply_volts};
         gshc_pkg::REG_LOAD_OHMS:   csr_prdata = cfg_ff.load_ohms;
         gshc_pkg::REG_CLEAN_OHMS:  csr_prdata = cfg_ff.clean_air_ohms;
         gshc_pkg::REG_CURVE_SCALE: csr_prdata = cfg_ff.curve_scale;
         gshc_pkg::REG_CURVE_EXP:   csr_prdata = {12'd0, cfg_ff.curve_exponent};
         default:                   csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/gshc_front.sv]
// front end: takes requests, runs the heater phase timer and classifies each item
// depends on gshc_pkg
`default_nettype none

module gshc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_type,
   input  wire logic [31:0]                   req_now_ms,
   input  wire logic [gshc_pkg::ADC_BITS-1:0] req_adc_sample,
   input  wire gshc_pkg::cfg_type             cfg,
   input  wire logic                          q_full,
   output logic                               q_push,
   output gshc_pkg::cmd_type                  q_data
);

   logic        phase_high_ff, phase_high_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] elapsed;
   logic [31:0] hi_dur;
   logic [31:0] lo_dur;
   logic        measure;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;
   assign elapsed  = req_now_ms - start_ff;
   assign hi_dur   = (cfg.high_phase_ms == 32'd0) ? gshc_pkg::HIGH_DEFAULT_MS : cfg.high_phase_ms;
   assign lo_dur   = (cfg.low_phase_ms == 32'd0) ? gshc_pkg::LOW_DEFAULT_MS : cfg.low_phase_ms;

   always_comb begin
      phase_high_in = phase_high_ff;
      start_in      = start_ff;
      measure       = 1'b0;
      if (!req_type) begin
         phase_high_in = 1'b1;
         start_in      = req_now_ms;
      end else if (phase_high_ff) begin
         if (elapsed >= hi_dur) begin
            phase_high_in = 1'b0;
            start_in      = req_now_ms;
         end
      end else if (elapsed >= lo_dur) begin
         measure       = 1'b1;
         phase_high_in = 1'b1;
         start_in      = req_now_ms;
      end
   end

   assign q_data.restart = !req_type;
   assign q_data.measure = measure;
   assign q_data.heater  = phase_high_in;
   assign q_data.sample  = req_adc_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_high_ff <= 1'b1;
         start_ff      <= 32'd0;
      end else if (q_push) begin
         phase_high_ff <= phase_high_in;
         start_ff      <= start_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/gshc_cmd_queue.sv]
// short command queue between the front end and the ppm engine
// depends on gshc_pkg
`default_nettype none

module gshc_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire gshc_pkg::cmd_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output gshc_pkg::cmd_type      head
);

   gshc_pkg::cmd_type                entry_ff [gshc_pkg::CMD_DEPTH];
   logic [gshc_pkg::CMD_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [gshc_pkg::CMD_CNT_W-1:0]   count_ff;
   logic                             do_push, do_pop;

   localparam logic [gshc_pkg::CMD_PTR_W-1:0] LAST_PTR =
      gshc_pkg::CMD_PTR_W'(gshc_pkg::CMD_DEPTH - 1);
   localparam logic [gshc_pkg::CMD_CNT_W-1:0] FULL_CNT =
      gshc_pkg::CMD_CNT_W'(gshc_pkg::CMD_DEPTH);

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/gshc_back.sv]
// back end: sequential power-law ppm engine, held reading and result register
// depends on gshc_pkg
`default_nettype none

module gshc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire gshc_pkg::cfg_type cfg,
   input  wire logic              cmd_empty,
   input  wire gshc_pkg::cmd_type cmd_head,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic                   rsp_heater_high,
   output logic [31:0]            rsp_ppm_value,
   output logic                   rsp_measured,
   output logic                   rsp_ppm_saturated
);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0_0000_0000_0001,
      ST_MUL_V    = 13'b0_0000_0000_0010,
      ST_CHECK_V  = 13'b0_0000_0000_0100,
      ST_MUL_N    = 13'b0_0000_0000_1000,
      ST_MUL_D    = 13'b0_0000_0001_0000,
      ST_CLASSIFY = 13'b0_0000_0010_0000,
      ST_NORM     = 13'b0_0000_0100_0000,
      ST_LOG      = 13'b0_0000_1000_0000,
      ST_MUL_Y    = 13'b0_0001_0000_0000,
      ST_EXP      = 13'b0_0010_0000_0000,
      ST_MUL_P    = 13'b0_0100_0000_0000,
      ST_SHIFT    = 13'b0_1000_0000_0000,
      ST_FINISH   = 13'b1_0000_0000_0000
   } back_state_type;

   back_state_type st_ff, st_in;

   gshc_pkg::cmd_type            cmd_ff, cmd_in;
   logic [gshc_pkg::VOLT_W-1:0]  v_ff, v_in;
   logic [27:0]                  diff_ff, diff_in;
   logic [59:0]                  n_ff, n_in, d_ff, d_in;
   logic [63:0]                  norm_ff, norm_in;
   logic [5:0]                   cnt_ff, cnt_in;
   logic [3:0]                   step_ff, step_in;
   logic [30:0]                  m_ff, m_in;
   logic [15:0]                  frac_ff, frac_in;
   logic [5:0]                   ipart_ff, ipart_in;
   logic [21:0]                  ln_ff, ln_in;
   logic signed [22:0]           lr_ff, lr_in;
   logic                         sel_d_ff, sel_d_in;
   logic [15:0]                  f_ff, f_in;
   logic signed [10:0]           k_ff, k_in;
   logic [30:0]                  acc_ff, acc_in;
   logic [62:0]                  p_ff, p_in;
   logic [31:0]                  res_ppm_ff, res_ppm_in;
   logic                         res_sat_ff, res_sat_in;
   logic [31:0]                  latest_ppm_ff, latest_ppm_in;
   logic                         latest_sat_ff, latest_sat_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_heater_ff, out_heater_in;
   logic [31:0]                  out_ppm_ff, out_ppm_in;
   logic                         out_meas_ff, out_meas_in;
   logic                         out_sat_ff, out_sat_in;

   logic                         out_free;
   logic                         out_write;
   logic [gshc_pkg::ADC_BITS-1:0] samp;
   logic [27:0]                  vs;
   logic signed [19:0]           b_exp;
   logic                         b_pos;
   logic                         norm_zero;
   logic [63:0]                  norm_shifted;
   logic [5:0]                   norm_amt;
   logic [63:0]                  norm_next;
   logic [5:0]                   cnt_next;
   logic [61:0]                  sq;
   logic [31:0]                  sq_top;
   logic [21:0]                  log_val;
   logic signed [42:0]           b_wide, lr_wide, prod_y;
   logic [62:0]                  exp_prod;
   logic signed [11:0]           sh_s;
   logic [11:0]                  sh_neg;
   logic [63:0]                  p_right;
   logic [62:0]                  p_limit;
   logic [62:0]                  p_left;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign samp      = (cmd_ff.sample == '0) ? gshc_pkg::ADC_BITS'(1) : cmd_ff.sample;
   assign vs        = {cfg.supply_volts, 8'd0};
   assign b_exp     = $signed(cfg.curve_exponent);
   assign b_pos     = !b_exp[19] && (b_exp != 20'sd0);
   assign b_wide    = 43'(b_exp);
   assign lr_wide   = 43'(lr_ff);
   assign prod_y    = b_wide * lr_wide;
   assign sq        = 62'(m_ff) * 62'(m_ff);
   assign sq_top    = sq[61:30];
   assign exp_prod  = 63'(acc_ff) * 63'(gshc_pkg::ROOT_TABLE[step_ff]);
   assign sh_s      = 12'sd38 - 12'(k_ff);
   assign sh_neg    = 12'(-sh_s);
   assign p_right   = {1'b0, p_ff} >> sh_s[5:0];
   assign p_limit   = {31'd0, 32'hFFFF_FFFF >> sh_neg[4:0]};
   assign p_left    = p_ff << sh_neg[4:0];

   // leading zero search, one halving step a cycle
   always_comb begin
      unique case (step_ff[2:0])
         3'd0: begin
            norm_zero    = (norm_ff[63:32] == '0);
            norm_shifted = {norm_ff[31:0], 32'd0};
            norm_amt     = 6'd32;
         end
         3'd1: begin
            norm_zero    = (norm_ff[63:48] == '0);
            norm_shifted = {norm_ff[47:0], 16'd0};
            norm_amt     = 6'd16;
         end
         3'd2: begin
            norm_zero    = (norm_ff[63:56] == '0);
            norm_shifted = {norm_ff[55:0], 8'd0};
            norm_amt     = 6'd8;
         end
         3'd3: begin
            norm_zero    = (norm_ff[63:60] == '0);
            norm_shifted = {norm_ff[59:0], 4'd0};
            norm_amt     = 6'd4;
         end
         3'd4: begin
            norm_zero    = (norm_ff[63:62] == '0);
            norm_shifted = {norm_ff[61:0], 2'd0};
            norm_amt     = 6'd2;
         end
         3'd5: begin
            norm_zero    = !norm_ff[63];
            norm_shifted = {norm_ff[62:0], 1'b0};
            norm_amt     = 6'd1;
         end
         default: begin
            norm_zero    = 1'b0;
            norm_shifted = norm_ff;
            norm_amt     = 6'd0;
         end
      endcase
      norm_next = norm_zero ? norm_shifted : norm_ff;
      cnt_next  = norm_zero ? cnt_ff + norm_amt : cnt_ff;
   end

   // used on the last log step: lowest fraction bit comes straight from the squarer
   assign log_val = {ipart_ff, frac_ff[15:1], sq_top[31]};

   always_comb begin
      st_in         = st_ff;
      cmd_in        = cmd_ff;
      v_in          = v_ff;
      diff_in       = diff_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      norm_in       = norm_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      m_in          = m_ff;
      frac_in       = frac_ff;
      ipart_in      = ipart_ff;
      ln_in         = ln_ff;
      lr_in         = lr_ff;
      sel_d_in      = sel_d_ff;
      f_in          = f_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      p_in          = p_ff;
      res_ppm_in    = res_ppm_ff;
      res_sat_in    = res_sat_ff;
      latest_ppm_in = latest_ppm_ff;
      latest_sat_in = latest_sat_ff;
      out_heater_in = out_heater_ff;
      out_ppm_in    = out_ppm_ff;
      out_meas_in   = out_meas_ff;
      out_sat_in    = out_sat_ff;
      out_write     = 1'b0;
      cmd_pop       = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (!cmd_empty && out_free) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_head;
               if (cmd_head.measure) begin
                  st_in = ST_MUL_V;
               end else begin
                  out_write     = 1'b1;
                  out_heater_in = cmd_head.heater;
                  out_meas_in   = 1'b0;
                  if (cmd_head.restart) begin
                     latest_ppm_in = 32'd0;
                     latest_sat_in = 1'b0;
                     out_ppm_in    = 32'd0;
                     out_sat_in    = 1'b0;
                  end else begin
                     out_ppm_in = latest_ppm_ff;
                     out_sat_in = latest_sat_ff;
                  end
               end
            end
         end
         ST_MUL_V: begin
            v_in  = gshc_pkg::VOLT_W'(samp) * gshc_pkg::VOLT_W'(cfg.volts_per_code);
            st_in = ST_CHECK_V;
         end
         ST_CHECK_V: begin
            if (v_ff >= gshc_pkg::VOLT_W'(vs)) begin
               res_ppm_in = 32'hFFFF_FFFF;
               res_sat_in = 1'b1;
               st_in      = ST_FINISH;
            end else begin
               diff_in = vs - v_ff[27:0];
               st_in   = ST_MUL_N;
            end
         end
         ST_MUL_N: begin
            n_in  = 60'(cfg.load_ohms) * 60'(diff_ff);
            st_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            d_in  = 60'(v_ff[27:0]) * 60'(cfg.clean_air_ohms);
            st_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            // a zero or infinite ratio skips the logarithm
            if (d_ff == '0 || n_ff == '0) begin
               if (b_exp == 20'sd0) begin
                  f_in    = 16'd0;
                  k_in    = 11'sd0;
                  acc_in  = 31'h4000_0000;
                  step_in = 4'd0;
                  st_in   = ST_EXP;
               end else if ((d_ff == '0) == b_pos) begin
                  res_ppm_in = 32'hFFFF_FFFF;
                  res_sat_in = 1'b1;
                  st_in      = ST_FINISH;
               end else begin
                  res_ppm_in = 32'd0;
                  res_sat_in = 1'b0;
                  st_in      = ST_FINISH;
               end
            end else begin
               norm_in  = {4'd0, n_ff};
               cnt_in   = 6'd0;
               step_in  = 4'd0;
               sel_d_in = 1'b0;
               st_in    = ST_NORM;
            end
         end
         ST_NORM: begin
            norm_in = norm_next;
            cnt_in  = cnt_next;
            if (step_ff == 4'd5) begin
               m_in     = norm_next[63:33];
               ipart_in = 6'd63 - cnt_next;
               frac_in  = 16'd0;
               step_in  = 4'd0;
               st_in    = ST_LOG;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_LOG: begin
            // squaring the mantissa yields one fraction bit, top bit first
            frac_in = frac_ff;
            frac_in[~step_ff] = sq_top[31];
            m_in = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
            if (step_ff == 4'd15) begin
               step_in = 4'd0;
               if (!sel_d_ff) begin
                  ln_in    = log_val;
                  norm_in  = {4'd0, d_ff};
                  cnt_in   = 6'd0;
                  sel_d_in = 1'b1;
                  st_in    = ST_NORM;
               end else begin
                  lr_in = $signed({1'b0, ln_ff}) - $signed({1'b0, log_val});
                  st_in = ST_MUL_Y;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_MUL_Y: begin
            f_in    = prod_y[31:16];
            k_in    = prod_y[42:32];
            acc_in  = 31'h4000_0000;
            step_in = 4'd0;
            st_in   = ST_EXP;
         end
         ST_EXP: begin
            if (f_ff[~step_ff]) begin
               acc_in = exp_prod[60:30];
            end
            if (step_ff == 4'd15) begin
               st_in = ST_MUL_P;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_MUL_P: begin
            p_in  = 63'(cfg.curve_scale) * 63'(acc_ff);
            st_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            res_sat_in = 1'b0;
            res_ppm_in = 32'd0;
            if (p_ff == '0) begin
               res_ppm_in = 32'd0;
            end else if (!sh_s[11]) begin
               if (sh_s[10:6] != '0) begin
                  res_ppm_in = 32'd0;
               end else if (p_right[63:32] != '0) begin
                  res_ppm_in = 32'hFFFF_FFFF;
                  res_sat_in = 1'b1;
               end else begin
                  res_ppm_in = p_right[31:0];
               end
            end else if (sh_neg[11:5] != '0 || p_ff > p_limit) begin
               res_ppm_in = 32'hFFFF_FFFF;
               res_sat_in = 1'b1;
            end else begin
               res_ppm_in = p_left[31:0];
            end
            st_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               latest_ppm_in = res_ppm_ff;
               latest_sat_in = res_sat_ff;
               out_write     = 1'b1;
               out_heater_in = cmd_ff.heater;
               out_ppm_in    = res_ppm_ff;
               out_meas_in   = 1'b1;
               out_sat_in    = res_sat_ff;
               st_in         = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase

      if (out_write) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         latest_ppm_ff <= 32'd0;
         latest_sat_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         out_valid_ff  <= out_valid_in;
         latest_ppm_ff <= latest_ppm_in;
         latest_sat_ff <= latest_sat_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      v_ff          <= v_in;
      diff_ff       <= diff_in;
      n_ff          <= n_in;
      d_ff          <= d_in;
      norm_ff       <= norm_in;
      cnt_ff        <= cnt_in;
      step_ff       <= step_in;
      m_ff          <= m_in;
      frac_ff       <= frac_in;
      ipart_ff      <= ipart_in;
      ln_ff         <= ln_in;
      lr_ff         <= lr_in;
      sel_d_ff      <= sel_d_in;
      f_ff          <= f_in;
      k_ff          <= k_in;
      acc_ff        <= acc_in;
      p_ff          <= p_in;
      res_ppm_ff    <= res_ppm_in;
      res_sat_ff    <= res_sat_in;
      out_heater_ff <= out_heater_in;
      out_ppm_ff    <= out_ppm_in;
      out_meas_ff   <= out_meas_in;
      out_sat_ff    <= out_sat_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_heater_high   = out_heater_ff;
   assign rsp_ppm_value     = out_ppm_ff;
   assign rsp_measured      = out_meas_ff;
   assign rsp_ppm_saturated = out_sat_ff;

endmodule

`default_nettype wire

[rtl/core/gas_sensor_heater_cycle_ppm_top.sv]
// an item that ends no low phase is registered in the command queue, then written to
// the response register by the idle engine; one ending a low phase runs the ppm engine
// (two 6-step normalisations, two 16-step log loops, a 16-step exp loop, multiplies)
// one item per cycle without measurement while responses pop; else busy until written
// reset is synchronous: registers to defaults, heater high, phase start 0, reading 0
// top level, depends on gshc_pkg, gshc_csr, gshc_front, gshc_cmd_queue, gshc_back
`default_nettype none
`include "gas_sensor_heater_cycle_ppm_top_defines.svh"

module gas_sensor_heater_cycle_ppm_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic                            req_type,
   input  wire logic [31:0]                     req_now_ms,
   input  wire logic [gshc_pkg::ADC_BITS-1:0]   req_adc_sample,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_heater_high,
   output logic [31:0]                          rsp_ppm_value,
   output logic                                 rsp_measured,
   output logic                                 rsp_ppm_saturated,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [gshc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   gshc_pkg::cfg_type cfg;
   gshc_pkg::cmd_type push_cmd, head_cmd;
   logic              cmd_push, cmd_full, cmd_empty, cmd_pop;

   gshc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gshc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_type       (req_type),
      .req_now_ms     (req_now_ms),
      .req_adc_sample (req_adc_sample),
      .cfg            (cfg),
      .q_full         (cmd_full),
      .q_push         (cmd_push),
      .q_data         (push_cmd)
   );

   gshc_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .head      (head_cmd)
   );

   gshc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd_empty         (cmd_empty),
      .cmd_head          (head_cmd),
      .cmd_pop           (cmd_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_heater_high   (rsp_heater_high),
      .rsp_ppm_value     (rsp_ppm_value),
      .rsp_measured      (rsp_measured),
      .rsp_ppm_saturated (rsp_ppm_saturated)
   );

   // a transferred request must be waiting in the queue on the next edge
   `GSHC_ASSERT_NEXT(a_push_lands, clock, reset, req_push && !req_full, !cmd_empty)
   `GSHC_ASSERT_IMPL(a_sat_all_ones, clock, reset, !rsp_empty && rsp_ppm_saturated, rsp_ppm_value == 32'hFFFF_FFFF)
   `GSHC_ASSERT_IMPL(a_measure_heats, clock, reset, !rsp_empty && rsp_measured, rsp_heater_high)

endmodule

`default_nettype wire

[tb/gas_sensor_heater_cycle_ppm_top_test.sv]
// self-checking testbench for the gas sensor heater cycle and ppm block
// drives items through the request queue, checks every response against a scripted value or a local predictor
// depends on gshc_pkg and gas_sensor_heater_cycle_ppm_top
`timescale 1ns / 100ps

module gas_sensor_heater_cycle_ppm_top_test;

   localparam logic REQ_RESTART = 1'b0;
   localparam logic REQ_UPDATE  = 1'b1;
   localparam int   STALL_LIMIT = 20000;
   localparam int   SETTLE_CYCLES = 80;

   typedef struct packed {
      logic        heater;
      logic [31:0] ppm;
      logic        measured;
      logic        saturated;
   } heater_reading_type;

   typedef struct packed {
      logic               kind;
      logic [31:0]        now;
      logic [11:0]        adc;
      logic               known;
      heater_reading_type want;
   } script_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_push;
   logic                            req_full;
   logic                            req_type;
   logic [31:0]                     req_now_ms;
   logic [gshc_pkg::ADC_BITS-1:0]   req_adc_sample;
   logic                            rsp_empty;
   logic                            rsp_pop;
   logic                            rsp_heater_high;
   logic [31:0]                     rsp_ppm_value;
   logic                            rsp_measured;
   logic                            rsp_ppm_saturated;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [gshc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                     csr_pwdata;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   gas_sensor_heater_cycle_ppm_top i_dut (.*);

   always #5 clock = ~clock;

   // predictor copy of configuration and heater state
   gshc_pkg::cfg_type cfg = '{gshc_pkg::RST_HIGH_PHASE, gshc_pkg::RST_LOW_PHASE,
                              gshc_pkg::RST_VOLTS_CODE, gshc_pkg::RST_SUPPLY,
                              gshc_pkg::RST_LOAD_OHMS, gshc_pkg::RST_CLEAN_OHMS,
                              gshc_pkg::RST_CURVE_SCALE, gshc_pkg::RST_CURVE_EXP};
   logic        heat_high = 1'b1;
   logic [31:0] heat_start = '0;
   logic [31:0] held_ppm = '0;
   logic        held_sat = 1'b0;

   heater_reading_type pending_readings[$];
   int errors = 0;
   int items_sent = 0;
   int measurements_seen = 0;
   int saturations_seen = 0;
   int push_idle_pct = 25;
   int pop_idle_pct = 25;
   int stall_cycles = 0;

   function automatic longint log2_q16(logic [63:0] x);
      int          pos;
      logic [63:0] m;
      longint      frac;
      pos  = 63;
      frac = 0;
      while (pos > 0 && !x[pos]) pos--;
      m = (pos >= 30) ? (x >> (pos - 30)) : (x << (30 - pos));
      for (int i = 15; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= 64'h8000_0000) begin
            frac = frac | (longint'(1) << i);
            m    = m >> 1;
         end
      end
      return longint'(pos) * 65536 + frac;
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= x && trial <= 64'hFFFF_FFFF) root = trial;
      end
      return root;
   endfunction

   // concentration from one sample, fixed point power law
   task automatic convert_sample(input logic [11:0] smp);
      logic [63:0] s, v, vs, n, d, acc, r, p;
      longint      b, y, k, sh;
      logic [15:0] f;
      s = {52'd0, smp};
      if (s == 0) s = 1;
      v  = s * {40'd0, cfg.volts_per_code};
      vs = {44'd0, cfg.supply_volts} << 8;
      held_sat = 1'b0;
      held_ppm = '0;
      if (v >= vs) begin
         held_ppm = '1;
         held_sat = 1'b1;
         return;
      end
      n = {32'd0, cfg.load_ohms} * (vs - v);
      d = v * {32'd0, cfg.clean_air_ohms};
      b = longint'($signed(cfg.curve_exponent));
      if (d == 0 || n == 0) begin
         if (b == 0) y = 0;
         else if ((d == 0) == (b > 0)) begin
            held_ppm = '1;
            held_sat = 1'b1;
            return;
         end else return;
      end else begin
         y = (b * (log2_q16(n) - log2_q16(d))) >>> 16;
      end
      f   = y[15:0];
      k   = y >>> 16;
      acc = 64'd1 << 30;
      r   = 64'd1 << 31;
      for (int i = 15; i >= 0; i--) begin
         r = floor_sqrt(r << 30);
         if (f[i]) acc = (acc * r) >> 30;
      end
      p  = {32'd0, cfg.curve_scale} * acc;
      sh = 38 - k;
      if (p == 0 || sh >= 64) return;
      if (sh >= 0) begin
         p = p >> sh;
         if (p > 64'hFFFF_FFFF) begin
            held_ppm = '1;
            held_sat = 1'b1;
         end else held_ppm = p[31:0];
         return;
      end
      sh = -sh;
      if (sh >= 32 || p > (64'hFFFF_FFFF >> sh)) begin
         held_ppm = '1;
         held_sat = 1'b1;
         return;
      end
      p = p << sh;
      held_ppm = p[31:0];
   endtask

   function automatic logic [31:0] phase_length(logic high);
      if (high) begin
         return (cfg.high_phase_ms == 0) ? gshc_pkg::HIGH_DEFAULT_MS : cfg.high_phase_ms;
      end
      return (cfg.low_phase_ms == 0) ? gshc_pkg::LOW_DEFAULT_MS : cfg.low_phase_ms;
   endfunction

   task automatic advance_heater(input logic kind, input logic [31:0] now,
                                 input logic [11:0] adc, output heater_reading_type res);
      logic [31:0] elapsed;
      logic        meas;
      elapsed = now - heat_start;
      meas    = 1'b0;
      if (kind == REQ_RESTART) begin
         heat_start = now;
         heat_high  = 1'b1;
         held_ppm   = '0;
         held_sat   = 1'b0;
      end else if (heat_high) begin
         if (elapsed >= phase_length(1'b1)) begin
            heat_high  = 1'b0;
            heat_start = now;
         end
      end else if (elapsed >= phase_length(1'b0)) begin
         convert_sample(adc);
         meas       = 1'b1;
         heat_high  = 1'b1;
         heat_start = now;
      end
      res = '{heat_high, held_ppm, meas, held_sat};
   endtask

   task automatic send_item(input logic kind, input logic [31:0] now, input logic [11:0] adc,
                            input logic known, input heater_reading_type want);
      heater_reading_type res;
      req_push       <= 1'b1;
      req_type       <= kind;
      req_now_ms     <= now;
      req_adc_sample <= adc;
      do @(posedge clock); while (req_full);
      advance_heater(kind, now, adc, res);
      pending_readings.push_back(known ? want : res);
      items_sent++;
      if ($urandom_range(99) < push_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < push_idle_pct);
      end
   endtask

   task automatic write_reg(input gshc_pkg::csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= gshc_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         gshc_pkg::REG_HIGH_PHASE:  cfg.high_phase_ms  = value;
         gshc_pkg::REG_LOW_PHASE:   cfg.low_phase_ms   = value;
         gshc_pkg::REG_VOLTS_CODE:  cfg.volts_per_code = value[23:0];
         gshc_pkg::REG_SUPPLY:      cfg.supply_volts   = value[19:0];
         gshc_pkg::REG_LOAD_OHMS:   cfg.load_ohms      = value;
         gshc_pkg::REG_CLEAN_OHMS:  cfg.clean_air_ohms = value;
         gshc_pkg::REG_CURVE_SCALE: cfg.curve_scale    = value;
         gshc_pkg::REG_CURVE_EXP:   cfg.curve_exponent = value[19:0];
         default: ;
      endcase
   endtask

   // sender holds off until every response is back, then the engine is allowed to settle
   task automatic drain;
      req_push <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      logic [31:0] now;
      logic [11:0] adc;
      logic [31:0] len;
      int          sel;
      for (int i = 0; i < count; i++) begin
         len = phase_length(heat_high);
         sel = $urandom_range(99);
         if (sel < 10) now = $urandom;
         else if (sel < 45) now = heat_start + len + $urandom_range(0, 2) - 1;
         else now = heat_start + $urandom_range(0, len);
         sel = $urandom_range(99);
         adc = (sel < 8) ? 12'd0 : (sel < 14) ? 12'hFFF : 12'($urandom_range(0, 4095));
         send_item(($urandom_range(99) < 6) ? REQ_RESTART : REQ_UPDATE, now, adc,
                   1'b0, '0);
      end
      drain();
   endtask

   // directed part, defaults after reset, including a wrap of the millisecond clock
   script_row_type bench_rows[12] = '{
      '{REQ_UPDATE,  32'd0,          12'h000, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b0}},
      '{REQ_UPDATE,  32'd59999,      12'hFFF, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b0}},
      '{REQ_UPDATE,  32'd60000,      12'h000, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b0}},
      '{REQ_UPDATE,  32'd149999,     12'h000, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b0}},
      '{REQ_UPDATE,  32'd150000,     12'h000, 1'b0, '0},
      '{REQ_UPDATE,  32'd150000,     12'hFFF, 1'b0, '0},
      '{REQ_RESTART, 32'hFFFF_FF00,  12'hFFF, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b0}},
      '{REQ_UPDATE,  32'h0000_E960,  12'h123, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b0}},
      '{REQ_UPDATE,  32'h0002_48F0,  12'h800, 1'b0, '0},
      '{REQ_RESTART, 32'd0,          12'hAAA, 1'b1, '{1'b1, 32'd0, 1'b0, 1'b0}},
      '{REQ_UPDATE,  32'd60000,      12'h555, 1'b1, '{1'b0, 32'd0, 1'b0, 1'b0}},
      '{REQ_UPDATE,  32'd150000,     12'h555, 1'b0, '0}
   };

   always @(posedge clock) begin
      if (reset) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   // response checker
   always @(posedge clock) begin
      heater_reading_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_readings.size() == 0) begin
            $error("response transfer with nothing expected");
            errors++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_heater_high !== want.heater) begin
               $error("heater_high expected %0d got %0d", want.heater, rsp_heater_high);
               errors++;
            end
            if (rsp_ppm_value !== want.ppm) begin
               $error("ppm_value expected %h got %h", want.ppm, rsp_ppm_value);
               errors++;
            end
            if (rsp_measured !== want.measured) begin
               $error("measured expected %0d got %0d", want.measured, rsp_measured);
               errors++;
            end
            if (rsp_ppm_saturated !== want.saturated) begin
               $error("ppm_saturated expected %0d got %0d", want.saturated, rsp_ppm_saturated);
               errors++;
            end
            if (rsp_measured === 1'b1) measurements_seen++;
            if (rsp_ppm_saturated === 1'b1 && rsp_measured === 1'b1) saturations_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset          <= 1'b1;
      req_push       <= 1'b0;
      req_type       <= REQ_UPDATE;
      req_now_ms     <= '0;
      req_adc_sample <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (bench_rows[i])
         send_item(bench_rows[i].kind, bench_rows[i].now, bench_rows[i].adc,
                   bench_rows[i].known, bench_rows[i].want);
      drain();

      // short phases, no idling on either side
      push_idle_pct = 0;
      pop_idle_pct  = 0;
      write_reg(gshc_pkg::REG_HIGH_PHASE, 32'd3);
      write_reg(gshc_pkg::REG_LOW_PHASE, 32'd5);
      run_random(120);
      push_idle_pct = 25;
      pop_idle_pct  = 25;

      // zero durations fall back to defaults; sample reaches supply
      write_reg(gshc_pkg::REG_HIGH_PHASE, 32'd0);
      write_reg(gshc_pkg::REG_LOW_PHASE, 32'd0);
      write_reg(gshc_pkg::REG_VOLTS_CODE, 32'h00FF_FFFF);
      write_reg(gshc_pkg::REG_SUPPLY, 32'h000F_FFFF);
      run_random(60);

      // infinite ratio with largest positive exponent
      write_reg(gshc_pkg::REG_HIGH_PHASE, 32'd1);
      write_reg(gshc_pkg::REG_LOW_PHASE, 32'd1);
      write_reg(gshc_pkg::REG_VOLTS_CODE, 32'd0);
      write_reg(gshc_pkg::REG_CURVE_EXP, 32'h0007_FFFF);
      run_random(50);

      // zero ratio with most negative exponent
      write_reg(gshc_pkg::REG_VOLTS_CODE, 32'd13521);
      write_reg(gshc_pkg::REG_LOAD_OHMS, 32'd0);
      write_reg(gshc_pkg::REG_CURVE_EXP, 32'h0008_0000);
      run_random(50);

      // zero clean air resistance and zero exponent, largest scale
      write_reg(gshc_pkg::REG_LOAD_OHMS, 32'hFFFF_FFFF);
      write_reg(gshc_pkg::REG_CLEAN_OHMS, 32'd0);
      write_reg(gshc_pkg::REG_CURVE_EXP, 32'd0);
      write_reg(gshc_pkg::REG_CURVE_SCALE, 32'hFFFF_FFFF);
      run_random(40);

      // longest phases, zero scale
      write_reg(gshc_pkg::REG_CLEAN_OHMS, 32'hFFFF_FFFF);
      write_reg(gshc_pkg::REG_CURVE_SCALE, 32'd0);
      write_reg(gshc_pkg::REG_HIGH_PHASE, 32'hFFFF_FFFF);
      write_reg(gshc_pkg::REG_LOW_PHASE, 32'hFFFF_FFFF);
      run_random(40);

      // random settings over the rest
      repeat (6) begin
         write_reg(gshc_pkg::REG_HIGH_PHASE, $urandom_range(0, 12));
         write_reg(gshc_pkg::REG_LOW_PHASE, $urandom_range(0, 12));
         write_reg(gshc_pkg::REG_VOLTS_CODE,
                   ($urandom_range(99) < 70) ? $urandom_range(1, 40000) : $urandom);
         write_reg(gshc_pkg::REG_SUPPLY,
                   ($urandom_range(99) < 70) ? $urandom_range(200000, 1048575) : $urandom);
         write_reg(gshc_pkg::REG_LOAD_OHMS, $urandom);
         write_reg(gshc_pkg::REG_CLEAN_OHMS, $urandom);
         write_reg(gshc_pkg::REG_CURVE_SCALE, $urandom);
         write_reg(gshc_pkg::REG_CURVE_EXP, $urandom);
         run_random(65);
      end

      if (pending_readings.size() != 0) begin
         $error("%0d responses never arrived", pending_readings.size());
         errors++;
      end
      $display("covered %0d items over several register settings, %0d measurements",
               items_sent, measurements_seen);
      $display("measurements clamped to full scale: %0d", saturations_seen);
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/gshc_pkg.sv
rtl/core/gshc_csr.sv
rtl/core/gshc_front.sv
rtl/core/gshc_cmd_queue.sv
rtl/core/gshc_back.sv
rtl/core/gas_sensor_heater_cycle_ppm_top.sv
tb/gas_sensor_heater_cycle_ppm_top_test.sv
